### rtl/assert_macros.svh
// Assertion macros for the port-level checker file.
// Depends on nothing; expects clk and arst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also holds through reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/blsm_pkg.sv
// Shared types, codes and character constants for the bracket loop stack machine.
// No dependencies.
`default_nettype none
package blsm_pkg;

	localparam logic [1:0] OP_LOAD    = 2'd0;
	localparam logic [1:0] OP_STEP    = 2'd1;
	localparam logic [1:0] OP_RESTART = 2'd2;

	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_NUM  = 2'd1;
	localparam logic [1:0] KIND_CHAR = 2'd2;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_HALT = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	localparam logic [7:0] CH_ZERO    = 8'd48;
	localparam logic [7:0] DIGIT_BASE = 8'd10;
	localparam logic [7:0] CH_ADD     = 8'h2B; // '+'
	localparam logic [7:0] CH_MUL     = 8'h2A; // '*'
	localparam logic [7:0] CH_NEG     = 8'h5F; // '_'
	localparam logic [7:0] CH_NOT     = 8'h3D; // '='
	localparam logic [7:0] CH_FETCH   = 8'h3A; // ':'
	localparam logic [7:0] CH_STORE   = 8'h3B; // ';'
	localparam logic [7:0] CH_BREAK   = 8'h5E; // '^'
	localparam logic [7:0] CH_LBR     = 8'h5B; // '['
	localparam logic [7:0] CH_RBR     = 8'h5D; // ']'
	localparam logic [7:0] CH_PNUM    = 8'h50; // 'P'
	localparam logic [7:0] CH_PCHR    = 8'h70; // 'p'

	typedef struct packed {
		logic accept;
		logic decode;
		logic operand;
		logic execute;
		logic seek_rd;
		logic seek_cmp;
		logic clear;
		logic out_load;
	} blsm_cmd_t;

	typedef struct packed {
		logic step_go;
		logic seek_go;
		logic seek_more;
		logic clr_last;
	} blsm_sts_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c < CH_ZERO + DIGIT_BASE);
	endfunction

endpackage
`default_nettype wire

### rtl/bracket_loop_stack_machine.sv
// A load, restart, unused op or halted step goes from accept straight to the result state;
// other steps first pass decode, operand read and execute, and a bracket jump then scans
// the program store one byte per read and compare state. One request in flight at a time.
// Reset (arst_n low, async) clears counters and program length, then the stack store is
// zeroed one word a cycle with in_ready low; cfg writes still land.
`default_nettype none
module bracket_loop_stack_machine #(
	parameter int PROG_DEPTH  = 2048,
	parameter int STACK_DEPTH = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request channel
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  op,
	input  wire logic [10:0] load_address,
	input  wire logic [7:0]  load_byte,
	// result channel
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic signed [31:0] print_value,
	output logic [1:0]       print_kind,
	output logic [1:0]       status,
	output logic [11:0]      next_address,
	output logic [10:0]      stack_count,
	// program_length register write
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [11:0] cfg_data
);
	import blsm_pkg::*;

	blsm_cmd_t cmd;
	blsm_sts_t sts;

	// register write is always taken
	assign cfg_ready = 1'b1;

	// sequencer: clear sweep, fetch, operand reads, execute, bracket scan, result
	blsm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// memories, pc/sp, ALU and output registers
	blsm_dp #(
		.PROG_DEPTH  (PROG_DEPTH),
		.STACK_DEPTH (STACK_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_we       (cfg_valid),
		.cfg_data     (cfg_data),
		.op           (op),
		.load_address (load_address),
		.load_byte    (load_byte),
		.print_value  (print_value),
		.print_kind   (print_kind),
		.status       (status),
		.next_address (next_address),
		.stack_count  (stack_count)
	);

endmodule
`default_nettype wire

### rtl/blsm_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none
module blsm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

### rtl/blsm_ctrl.sv
// Controller state machine for the bracket loop stack machine.
// Depends on blsm_pkg for the command and status structs.
`default_nettype none
module blsm_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	input  wire blsm_pkg::blsm_sts_t sts,
	output blsm_pkg::blsm_cmd_t    cmd
);
	import blsm_pkg::*;

	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_DEC  = 3'd2;
	localparam logic [2:0] S_OPR  = 3'd3;
	localparam logic [2:0] S_EXE  = 3'd4;
	localparam logic [2:0] S_SRD  = 3'd5;
	localparam logic [2:0] S_SCMP = 3'd6;
	localparam logic [2:0] S_DONE = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_nxt;
	logic       out_valid_q;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			S_CLR: begin
				cmd.clear = 1'b1;
				if (sts.clr_last) state_nxt = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_nxt  = sts.step_go ? S_DEC : S_DONE;
				end
			end
			S_DEC: begin
				cmd.decode = 1'b1;
				state_nxt  = S_OPR;
			end
			S_OPR: begin
				cmd.operand = 1'b1;
				state_nxt   = S_EXE;
			end
			S_EXE: begin
				cmd.execute = 1'b1;
				state_nxt   = sts.seek_go ? S_SRD : S_DONE;
			end
			S_SRD: begin
				cmd.seek_rd = 1'b1;
				state_nxt   = sts.seek_more ? S_SCMP : S_DONE;
			end
			S_SCMP: begin
				cmd.seek_cmp = 1'b1;
				state_nxt    = S_SRD;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

### rtl/blsm_dp.sv
// Datapath: program and stack memories, counters, ALU and result registers.
// Depends on blsm_pkg and blsm_ram.
`default_nettype none
module blsm_dp #(
	parameter int PROG_DEPTH  = 2048,
	parameter int STACK_DEPTH = 1024
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire blsm_pkg::blsm_cmd_t cmd,
	output blsm_pkg::blsm_sts_t      sts,
	input  wire logic                cfg_we,
	input  wire logic [11:0]         cfg_data,
	input  wire logic [1:0]          op,
	input  wire logic [10:0]         load_address,
	input  wire logic [7:0]          load_byte,
	output logic signed [31:0]       print_value,
	output logic [1:0]               print_kind,
	output logic [1:0]               status,
	output logic [11:0]              next_address,
	output logic [10:0]              stack_count
);
	import blsm_pkg::*;

	localparam int PAW = $clog2(PROG_DEPTH);
	localparam int PCW = $clog2(PROG_DEPTH + 1);
	localparam int SAW = $clog2(STACK_DEPTH);
	localparam int SPW = $clog2(STACK_DEPTH + 1);
	localparam int IW  = ((SPW + 1 > 32) ? SPW + 1 : 32) + 2;
	localparam int LCW = (PCW > 12) ? PCW : 12;
	localparam int LAW = (PCW > 11) ? PCW : 11;

	function automatic logic in_rng(input logic signed [IW-1:0] i);
		return !i[IW-1] && (i < $signed(IW'(STACK_DEPTH)));
	endfunction

	// architectural state
	logic [11:0]        plen_q;
	logic [PCW-1:0]     pc_q;
	logic [SPW-1:0]     sp_q;
	logic [SAW-1:0]     clr_q;
	// per-item working registers
	logic [7:0]         c_q;
	logic               prevdig_q;
	logic [31:0]        b_q;
	logic               v1_q;
	logic               v2_q;
	logic signed [PCW:0] at_q;
	logic [PCW:0]       lvl_q;
	logic               fwd_q;
	logic [31:0]        r_pval_q;
	logic [1:0]         r_kind_q;
	logic [1:0]         r_stat_q;
	// output registers
	logic [31:0]        o_pval_q;
	logic [1:0]         o_kind_q;
	logic [1:0]         o_stat_q;
	logic [PCW-1:0]     o_pc_q;
	logic [SPW-1:0]     o_sp_q;

	// memories
	logic           p_we;
	logic [PAW-1:0] p_raddr;
	logic [7:0]     p_rdata;
	logic           s_we;
	logic [SAW-1:0] s_waddr;
	logic [31:0]    s_wdata;
	logic [SAW-1:0] s_raddr;
	logic [31:0]    s_rdata;

	logic [LCW-1:0]       plen_x;
	logic [PCW-1:0]       eff_len;
	logic                 at_end;
	logic                 load_ok;
	logic signed [IW-1:0] sp_i;
	logic signed [IW-1:0] idx1;
	logic signed [IW-1:0] idx2;
	logic [31:0]          b_now;
	logic [31:0]          a_val;
	logic [7:0]           dig;
	logic [SPW-1:0]       sp_dec1;
	logic [SPW-1:0]       sp_dec2;
	logic                 e_we;
	logic signed [IW-1:0] e_idx;
	logic [31:0]          e_wdata;
	logic [SPW-1:0]       e_sp;
	logic                 e_seek;
	logic                 e_fwd;
	logic [1:0]           e_stat;
	logic [1:0]           e_kind;
	logic [31:0]          e_pval;
	logic [7:0]           seek_up;
	logic [7:0]           seek_dn;

	// effective program length, clamped to the store size
	assign plen_x  = LCW'(plen_q);
	assign eff_len = PCW'((plen_x > LCW'(PROG_DEPTH)) ? LCW'(PROG_DEPTH) : plen_x);
	assign at_end  = (pc_q >= eff_len);
	assign load_ok = (LAW'(load_address) < LAW'(PROG_DEPTH));

	assign sp_i  = $signed(IW'(sp_q));
	assign idx1  = sp_i - IW'(1);
	assign b_now = v1_q ? s_rdata : 32'd0;
	assign idx2  = (c_q == CH_FETCH) ? sp_i - IW'($signed(b_now)) - IW'(2) : sp_i - IW'(2);
	assign a_val = v2_q ? s_rdata : 32'd0;
	assign dig   = c_q - CH_ZERO;

	assign sp_dec1 = (sp_q == '0) ? '0 : sp_q - SPW'(1);
	assign sp_dec2 = (sp_q < SPW'(2)) ? '0 : sp_q - SPW'(2);

	// instruction execute
	always_comb begin
		e_we    = 1'b0;
		e_idx   = sp_i - IW'(1);
		e_wdata = b_q;
		e_sp    = sp_q;
		e_seek  = 1'b0;
		e_fwd   = 1'b0;
		e_stat  = ST_OK;
		e_kind  = KIND_NONE;
		e_pval  = 32'd0;
		if (is_digit(c_q)) begin
			if (prevdig_q) begin
				e_we    = 1'b1;
				e_wdata = b_q * 32'(DIGIT_BASE) + 32'(dig);
			end else if (sp_q == SPW'(STACK_DEPTH)) begin
				e_stat = ST_FULL;
			end else begin
				e_we    = 1'b1;
				e_idx   = sp_i;
				e_wdata = 32'(dig);
				e_sp    = sp_q + SPW'(1);
			end
		end else begin
			unique case (c_q)
				CH_ADD: begin
					e_we    = 1'b1;
					e_idx   = sp_i - IW'(2);
					e_wdata = a_val + b_q;
					e_sp    = sp_dec1;
				end
				CH_MUL: begin
					e_we    = 1'b1;
					e_idx   = sp_i - IW'(2);
					e_wdata = a_val * b_q;
					e_sp    = sp_dec1;
				end
				CH_NEG: begin
					e_we    = 1'b1;
					e_wdata = 32'd0 - b_q;
				end
				CH_NOT: begin
					e_we    = 1'b1;
					e_wdata = {31'd0, (b_q == 32'd0)};
				end
				CH_FETCH: begin
					e_we    = 1'b1;
					e_wdata = a_val;
				end
				CH_STORE: begin
					e_we    = 1'b1;
					e_idx   = sp_i - IW'($signed(b_q)) - IW'(3);
					e_wdata = a_val;
					e_sp    = sp_dec2;
				end
				CH_BREAK: begin
					e_sp   = sp_dec1;
					e_seek = (b_q != 32'd0);
					e_fwd  = 1'b1;
				end
				CH_RBR: begin
					e_seek = 1'b1;
				end
				CH_PNUM: begin
					e_sp   = sp_dec1;
					e_pval = b_q;
					e_kind = KIND_NUM;
				end
				CH_PCHR: begin
					e_sp   = sp_dec1;
					e_pval = b_q;
					e_kind = KIND_CHAR;
				end
				default: ;
			endcase
		end
	end

	assign seek_up = fwd_q ? CH_LBR : CH_RBR;
	assign seek_dn = fwd_q ? CH_RBR : CH_LBR;

	assign sts.step_go   = (op == OP_STEP) && !at_end;
	assign sts.seek_go   = e_seek;
	assign sts.seek_more = (lvl_q != '0) &&
		(fwd_q ? (at_q < $signed({1'b0, eff_len})) : !at_q[PCW]);
	assign sts.clr_last  = (clr_q == SAW'(STACK_DEPTH - 1));

	// memory ports
	assign p_we = cmd.accept && (op == OP_LOAD) && load_ok;
	always_comb begin
		if (cmd.decode) p_raddr = PAW'(pc_q - PCW'(1));
		else if (cmd.seek_rd) p_raddr = PAW'(at_q);
		else p_raddr = PAW'(pc_q);
	end

	assign s_we    = cmd.clear || (cmd.execute && e_we && in_rng(e_idx));
	assign s_waddr = cmd.clear ? clr_q : e_idx[SAW-1:0];
	assign s_wdata = cmd.clear ? 32'd0 : e_wdata;
	assign s_raddr = cmd.decode ? idx1[SAW-1:0] : idx2[SAW-1:0];

	blsm_ram #(.WIDTH(8), .DEPTH(PROG_DEPTH)) u_prog (
		.clk   (clk),
		.we    (p_we),
		.waddr (PAW'(load_address)),
		.wdata (load_byte),
		.raddr (p_raddr),
		.rdata (p_rdata)
	);

	blsm_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (s_wdata),
		.raddr (s_raddr),
		.rdata (s_rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q <= '0;
			pc_q   <= '0;
			sp_q   <= '0;
			clr_q  <= '0;
		end else begin
			if (cfg_we) plen_q <= cfg_data;
			if (cmd.clear) clr_q <= clr_q + SAW'(1);
			if (cmd.accept && op == OP_RESTART) pc_q <= '0;
			if (cmd.execute) begin
				sp_q <= e_sp;
				if (!e_seek) pc_q <= pc_q + PCW'(1);
			end
			if (cmd.seek_rd && !sts.seek_more) begin
				pc_q <= fwd_q ? PCW'(at_q) : PCW'(at_q + (PCW+1)'(1));
			end
		end
	end

	// working and result registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			r_pval_q <= 32'd0;
			r_kind_q <= KIND_NONE;
			r_stat_q <= (op == OP_STEP && at_end) ? ST_HALT : ST_OK;
		end
		if (cmd.decode) begin
			c_q  <= p_rdata;
			v1_q <= in_rng(idx1);
		end
		if (cmd.operand) begin
			prevdig_q <= (pc_q != '0) && is_digit(p_rdata);
			b_q       <= b_now;
			v2_q      <= in_rng(idx2);
		end
		if (cmd.execute) begin
			r_pval_q <= e_pval;
			r_kind_q <= e_kind;
			r_stat_q <= e_stat;
			fwd_q    <= e_fwd;
			lvl_q    <= (PCW+1)'(1);
			at_q     <= e_fwd ? $signed({1'b0, pc_q}) + (PCW+1)'(1)
			                  : $signed({1'b0, pc_q}) - (PCW+1)'(1);
		end
		if (cmd.seek_cmp) begin
			if (p_rdata == seek_up) lvl_q <= lvl_q + (PCW+1)'(1);
			else if (p_rdata == seek_dn) lvl_q <= lvl_q - (PCW+1)'(1);
			at_q <= fwd_q ? at_q + (PCW+1)'(1) : at_q - (PCW+1)'(1);
		end
		if (cmd.out_load) begin
			o_pval_q <= r_pval_q;
			o_kind_q <= r_kind_q;
			o_stat_q <= r_stat_q;
			o_pc_q   <= pc_q;
			o_sp_q   <= sp_q;
		end
	end

	assign print_value  = $signed(o_pval_q);
	assign print_kind   = o_kind_q;
	assign status       = o_stat_q;
	assign next_address = 12'(o_pc_q);
	assign stack_count  = 11'(o_sp_q);

endmodule
`default_nettype wire

### rtl/blsm_checker.sv
// Port-level checker for bracket_loop_stack_machine, bound to the top level.
// Depends on blsm_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module blsm_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic signed [31:0] print_value,
	input wire logic [1:0]  print_kind,
	input wire logic [1:0]  status
);
	import blsm_pkg::*;

	`ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped before taken")
	`ASSERT_CLK(a_one_item, in_valid && in_ready |=> !in_ready, "second request taken back to back")
	`ASSERT_CLK(a_quiet_val, out_valid && print_kind == KIND_NONE |-> print_value == 32'sd0, "value without print")
	`ASSERT_ALWAYS(a_stat_clean, out_valid && status != ST_OK |-> print_kind == KIND_NONE, "print on fault")

endmodule

bind bracket_loop_stack_machine blsm_checker u_blsm_checker (.*);
`default_nettype wire

### sim/testbench.sv
// Self-checking testbench for bracket_loop_stack_machine: directed table, random programs, stack fill.
// Depends on rtl/blsm_pkg.sv and rtl/bracket_loop_stack_machine.sv.
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import blsm_pkg::*;

	typedef struct packed {
		logic signed [31:0] value;
		logic [1:0]         kind;
		logic [1:0]         st;
		logic [11:0]        pc;
		logic [10:0]        depth;
	} result_t;

	typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t  kind;
		logic [1:0] op;
		logic [10:0] addr;
		logic [11:0] data;   // program byte for a request, length for a write
		bit         typed;
		result_t    res;
	} row_t;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
	logic [1:0] op, print_kind, status;
	logic [10:0] load_address, stack_count;
	logic [7:0] load_byte;
	logic signed [31:0] print_value;
	logic [11:0] next_address, cfg_data;

	bracket_loop_stack_machine u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .load_address(load_address), .load_byte(load_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.print_value(print_value), .print_kind(print_kind), .status(status),
		.next_address(next_address), .stack_count(stack_count),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// Shadow of the machine state.
	logic [7:0]  prog_mem [2048];
	logic [31:0] stack_mem [1024];
	logic [11:0] pc_reg, length_reg;
	logic [10:0] sp_reg;

	result_t pending_results[$];
	int errors, n_requests, n_prints, n_full, n_halts;
	int send_idle, recv_stall;

	localparam logic [7:0] OP_CHARS [11] = '{CH_ADD, CH_MUL, CH_NEG, CH_NOT, CH_FETCH,
		CH_STORE, CH_BREAK, CH_LBR, CH_RBR, CH_PNUM, CH_PCHR};

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("TIMEOUT with %0d results outstanding", pending_results.size());
		$display("Some tests failed");
		$finish;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall);
	end

	// ---------------------------------------------------------------- predictor
	function automatic logic [31:0] stack_rd(longint i);
		if (i < 0 || i >= 1024) return 0;
		return stack_mem[i];
	endfunction

	function automatic void stack_wr(longint i, logic [31:0] v);
		if (i >= 0 && i < 1024) stack_mem[i] = v;
	endfunction

	function automatic bit is_num_char(logic [7:0] c);
		return c >= CH_ZERO && c <= CH_ZERO + 8'd9;
	endfunction

	// Walk until the bracket nesting returns to zero; stops at either end of the program.
	function automatic longint bracket_seek(longint from, logic [7:0] up, logic [7:0] down,
			longint dir, longint len);
		longint at = from + dir;
		longint lvl = 1;
		while (at >= 0 && at < len && lvl > 0) begin
			if (prog_mem[at] == up) lvl++;
			if (prog_mem[at] == down) lvl--;
			at += dir;
		end
		return at;
	endfunction

	function automatic result_t machine_apply(logic [1:0] req_op, logic [10:0] addr,
			logic [7:0] data);
		result_t r = '0;
		longint len = (length_reg > 12'd2048) ? 2048 : length_reg;
		longint pc, sp, x;
		logic [31:0] a, b;
		logic [7:0] c;
		if (req_op == OP_LOAD) begin
			prog_mem[addr] = data;
		end else if (req_op == OP_RESTART) begin
			pc_reg = 0;
		end else if (req_op == OP_STEP) begin
			if (pc_reg >= len) begin
				r.st = ST_HALT;
			end else begin
				pc = pc_reg;
				sp = sp_reg;
				c = prog_mem[pc];
				if (is_num_char(c)) begin
					if (pc > 0 && is_num_char(prog_mem[pc - 1])) begin
						stack_wr(sp - 1, stack_rd(sp - 1) * 10 + (c - CH_ZERO));
					end else if (sp >= 1024) begin
						r.st = ST_FULL;
					end else begin
						stack_wr(sp, c - CH_ZERO);
						sp++;
					end
				end else begin
					case (c)
						CH_ADD, CH_MUL: begin
							a = stack_rd(sp - 2);
							b = stack_rd(sp - 1);
							stack_wr(sp - 2, (c == CH_ADD) ? a + b : a * b);
							sp--;
						end
						CH_NEG: stack_wr(sp - 1, -stack_rd(sp - 1));
						CH_NOT: stack_wr(sp - 1, (stack_rd(sp - 1) == 0) ? 32'd1 : 32'd0);
						CH_FETCH: begin
							x = longint'($signed(stack_rd(sp - 1)));
							stack_wr(sp - 1, stack_rd(sp - x - 2));
						end
						CH_STORE: begin
							x = longint'($signed(stack_rd(sp - 1)));
							a = stack_rd(sp - 2);
							sp -= 2;
							stack_wr(sp - x - 1, a);
						end
						CH_BREAK: begin
							sp--;
							if (stack_rd(sp) != 0) pc = bracket_seek(pc, CH_LBR, CH_RBR, 1, len) - 1;
						end
						CH_RBR: pc = bracket_seek(pc, CH_RBR, CH_LBR, -1, len);
						CH_PNUM, CH_PCHR: begin
							sp--;
							r.value = stack_rd(sp);
							r.kind = (c == CH_PNUM) ? KIND_NUM : KIND_CHAR;
						end
						default: ;
					endcase
				end
				if (sp < 0) sp = 0;
				pc++;
				if (pc < 0) pc = 0;
				pc_reg = pc[11:0];
				sp_reg = sp[10:0];
			end
		end
		r.pc = pc_reg;
		r.depth = sp_reg;
		return r;
	endfunction

	// ---------------------------------------------------------------- checking
	task automatic report_mismatch(string field, longint got, longint want);
		$display("[%0t] MISMATCH %s: got %0d expected %0d", $realtime, field, got, want);
		errors++;
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", 1, 0);
			end else begin
				want = pending_results.pop_front();
				if (print_value !== want.value) report_mismatch("print_value", print_value, want.value);
				if (print_kind !== want.kind) report_mismatch("print_kind", print_kind, want.kind);
				if (status !== want.st) report_mismatch("status", status, want.st);
				if (next_address !== want.pc) report_mismatch("next_address", next_address, want.pc);
				if (stack_count !== want.depth) report_mismatch("stack_count", stack_count, want.depth);
			end
		end
	end

	// ---------------------------------------------------------------- driving
	// Issue one request; valid stays high into the next request when no gap is drawn.
	task automatic send_request(logic [1:0] req_op, logic [10:0] addr, logic [7:0] data,
			bit typed = 0, result_t typed_res = '0);
		result_t r;
		if ($urandom_range(99) < send_idle) begin
			in_valid <= 0;
			do @(posedge clk); while ($urandom_range(99) < send_idle);
		end
		in_valid <= 1;
		op <= req_op;
		load_address <= addr;
		load_byte <= data;
		do @(posedge clk); while (!in_ready);
		r = machine_apply(req_op, addr, data);
		n_requests++;
		if (r.kind != KIND_NONE) n_prints++;
		if (r.st == ST_FULL) n_full++;
		if (r.st == ST_HALT) n_halts++;
		pending_results.push_back(typed ? typed_res : r);
	endtask

	task automatic drain;
		in_valid <= 0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Length register is only written with the machine idle.
	task automatic write_length(logic [11:0] v);
		drain();
		cfg_valid <= 1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		length_reg = v;
	endtask

	function automatic logic [7:0] pick_char();
		int roll = $urandom_range(99);
		if (roll < 38) return CH_ZERO + 8'($urandom_range(9));
		if (roll < 94) return OP_CHARS[$urandom_range(10)];
		return 8'($urandom_range(255));
	endfunction

	task automatic set_idling(int mode);
		case (mode % 4)
			0: begin send_idle = 0;  recv_stall = 0;  end
			1: begin send_idle = 62; recv_stall = 0;  end
			2: begin send_idle = 0;  recv_stall = 62; end
			default: begin send_idle = 19; recv_stall = 19; end
		endcase
	endtask

	// ---------------------------------------------------------------- stimulus
	row_t dir_rows[$];

	task automatic add_row(row_kind_t kind, logic [1:0] o, logic [10:0] a, logic [11:0] d,
			bit typed, result_t res = '0);
		row_t row;
		row.kind = kind; row.op = o; row.addr = a; row.data = d;
		row.typed = typed; row.res = res;
		dir_rows.push_back(row);
	endtask

	initial begin
		int len, steps, phase, roll;
		result_t halted;
		logic [7:0] dir_prog [10];
		arst_n = 0;
		in_valid = 0; op = OP_LOAD; load_address = 0; load_byte = 0;
		cfg_valid = 0; cfg_data = 0;
		errors = 0; n_requests = 0; n_prints = 0; n_full = 0; n_halts = 0;
		send_idle = 0; recv_stall = 0;
		foreach (stack_mem[i]) stack_mem[i] = 0;
		foreach (prog_mem[i]) prog_mem[i] = 0;
		pc_reg = 0; sp_reg = 0; length_reg = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;

		// Directed: halt at length zero, unused op, restart, then a short program that
		// builds 99, multiplies, negates, prints, hits a zero byte, underflows the empty stack
		// and finally falls off the front through an unmatched ']'.
		halted = '0;
		halted.st = ST_HALT;
		add_row(ROW_REQ, OP_STEP, 0, 0, 1, halted);
		add_row(ROW_REQ, 2'd3, 11'h7FF, 8'hFF, 1);
		add_row(ROW_REQ, OP_RESTART, 0, 0, 1);
		dir_prog = '{CH_ZERO + 8'd9, CH_ZERO + 8'd9, CH_MUL, CH_NEG, CH_PNUM, 8'h00,
			CH_NOT, CH_PCHR, CH_BREAK, CH_RBR};
		foreach (dir_prog[i]) add_row(ROW_REQ, OP_LOAD, 11'(i), dir_prog[i], 1);
		add_row(ROW_REQ, OP_LOAD, 11'h7FF, 8'hFF, 1);
		add_row(ROW_CFG, 0, 0, 12'd10, 0);
		for (int i = 0; i < 11; i++) add_row(ROW_REQ, OP_STEP, 0, 0, 0);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG) write_length(dir_rows[i].data);
			else send_request(dir_rows[i].op, dir_rows[i].addr, 8'(dir_rows[i].data),
				dir_rows[i].typed, dir_rows[i].res);
		end

		// Random programs: each phase loads a fresh prefix, sets the length over written
		// bytes only, restarts and runs. Loads, restarts and unused ops are mixed into the steps.
		// The stack fill below needs a little over 2k requests on its own.
		phase = 0;
		while (n_requests < 450) begin
			drain();
			set_idling(phase);
			len = ($urandom_range(9) == 0) ? $urandom_range(60, 300) : $urandom_range(3, 40);
			for (int i = 0; i < len; i++) send_request(OP_LOAD, 11'(i), pick_char());
			write_length(($urandom_range(7) == 0) ? 12'($urandom_range(len)) : 12'(len));
			send_request(OP_RESTART, 11'($urandom), 8'($urandom));
			steps = $urandom_range(len, 3 * len + 20);
			for (int i = 0; i < steps; i++) begin
				roll = $urandom_range(99);
				if (roll < 4) send_request(OP_RESTART, 11'($urandom), 8'($urandom));
				else if (roll < 7) send_request(2'd3, 11'($urandom), 8'($urandom));
				else if (roll < 11) send_request(OP_LOAD, 11'($urandom), pick_char());
				else send_request(OP_STEP, 11'($urandom), 8'($urandom));
			end
			phase++;
		end

		// Fill the stack with a push loop at the largest length setting, run past full,
		// then repeat at exactly the store depth. The loop body is sixteen pushes split
		// by zero bytes, about two steps a push; brackets keep the counter in range.
		drain();
		set_idling(0);
		send_request(OP_LOAD, 0, CH_LBR);
		for (int i = 0; i < 16; i++) begin
			send_request(OP_LOAD, 11'(1 + 2 * i), CH_ZERO + 8'd7);
			send_request(OP_LOAD, 11'(2 + 2 * i), 8'h00);
		end
		send_request(OP_LOAD, 11'd33, CH_RBR);
		write_length(12'hFFF);
		send_request(OP_RESTART, 0, 0);
		for (int i = 0; i < 2 * 1024 + 200; i++) send_request(OP_STEP, 0, 0);
		set_idling(3);
		write_length(12'd2048);
		send_request(OP_RESTART, 0, 0);
		for (int i = 0; i < 12; i++) send_request(OP_STEP, 0, 0);

		drain();
		repeat (50) @(posedge clk);
		$display("Ran %0d requests over %0d random phases plus directed and full-stack runs;",
			n_requests, phase);
		$display("saw %0d prints, %0d halts, %0d dropped pushes.", n_prints, n_halts, n_full);
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule
`default_nettype wire
